/* rtl/bounded_line_deframer_unit_macros.svh */
// Assertion macros used by the checker file of the line deframer.
`ifndef BOUNDED_LINE_DEFRAMER_UNIT_MACROS_SVH
`define BOUNDED_LINE_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("line deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("line deframer check failed");

`endif

/* rtl/bld_pkg.sv */
// Package of the line deframer: byte codes, defaults and controller states.
`default_nettype none
package bld_pkg;

	localparam int LINE_BYTES_DEF = 64;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] CR_BYTE      = 8'h0D;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

endpackage
`default_nettype wire

/* rtl/bounded_line_deframer_unit.sv */
// Bounded line deframer: top level joining the controller and the line store.
// Cuts a byte stream into newline-terminated lines of at most MAX_LINE_BYTES
// bytes. A data byte is written to the line store unless the line is already
// full. A newline ends the line, and an accepted line is then replayed from
// the store byte by byte (store read, then output register load); a load
// waits while the output stalls. Input is not taken while a line is being
// replayed; the last byte of a line may still wait in the output register
// while new bytes are taken. Overflowed lines are dropped at their newline,
// one trailing CR is stripped, and empty lines produce no output. No clearing
// pass after reset.
`default_nettype none
module bounded_line_deframer_unit #(
	parameter int MAX_LINE_BYTES = bld_pkg::LINE_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] line_byte,
	output logic            end_of_line
);

	localparam int AW = $clog2(MAX_LINE_BYTES);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	bld_ctrl #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_byte  (line_byte),
		.end_of_line(end_of_line),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	bld_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LINE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
`default_nettype wire

/* rtl/bld_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bld_pkg::LINE_BYTES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/bld_ctrl.sv */
// Line deframer controller: byte append, newline handling, replay and output register.
`default_nettype none
module bld_ctrl #(
	parameter int MAX_LINE_BYTES = bld_pkg::LINE_BYTES_DEF,
	localparam int AW = $clog2(MAX_LINE_BYTES),
	localparam int LW = $clog2(MAX_LINE_BYTES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic      [7:0]    line_byte,
	output logic               end_of_line,
	output logic               ram_we,
	output logic      [AW-1:0] ram_waddr,
	output logic      [7:0]    ram_wdata,
	output logic               ram_re,
	output logic      [AW-1:0] ram_raddr,
	input  wire logic [7:0]    ram_rdata
);

	bld_pkg::state_t state_q, state_d;

	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          last_cr_q;
	logic [AW-1:0] k_q;
	logic [LW-1:0] emit_len_q;
	logic          out_valid_q;
	logic [7:0]    line_byte_q;
	logic          eol_q;

	logic          in_acc;
	logic          is_nl;
	logic          at_limit;
	logic          out_free;
	logic [LW-1:0] eff_len;
	logic          is_last;
	logic          load;

	always_comb begin
		in_acc   = in_valid && in_ready;
		is_nl    = (in_byte == bld_pkg::NEWLINE_BYTE);
		at_limit = (len_q >= LW'(MAX_LINE_BYTES));
		out_free = !out_valid_q || out_ready;
		// one trailing CR comes off
		eff_len  = len_q - LW'(last_cr_q && (len_q != '0));
		is_last  = ((LW'(k_q) + LW'(1)) == emit_len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bld_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			bld_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && is_nl && !ovf_q && (eff_len != '0)) begin
					state_d = bld_pkg::ST_READ;
				end
			end
			bld_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = bld_pkg::ST_LOAD;
			end
			bld_pkg::ST_LOAD: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = is_last ? bld_pkg::ST_IDLE : bld_pkg::ST_READ;
				end
			end
			default: begin
				state_d = bld_pkg::ST_IDLE;
			end
		endcase
	end

	assign ram_we    = in_acc && !is_nl && !at_limit;
	assign ram_waddr = len_q[AW-1:0];
	assign ram_wdata = in_byte;
	assign ram_raddr = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			last_cr_q   <= 1'b0;
			k_q         <= '0;
			emit_len_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (is_nl) begin
					len_q      <= '0;
					ovf_q      <= 1'b0;
					emit_len_q <= eff_len;
					k_q        <= '0;
				end else if (at_limit) begin
					// overflow: drop what is held, keep filling from the start
					ovf_q <= 1'b1;
					len_q <= '0;
				end else begin
					len_q     <= len_q + LW'(1);
					last_cr_q <= (in_byte == bld_pkg::CR_BYTE);
				end
			end
			if (load) begin
				k_q         <= k_q + AW'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_byte_q <= ram_rdata;
			eol_q       <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_byte   = line_byte_q;
	assign end_of_line = eol_q;

endmodule
`default_nettype wire

/* rtl/bld_checker.sv */
// Port-level checks of the line deframer and their bind to the top level.
`default_nettype none
`include "bounded_line_deframer_unit_macros.svh"
module bld_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] in_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] line_byte,
	input wire logic       end_of_line
);

	// stalled output beat holds
	`BLD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(line_byte) && $stable(end_of_line))

	// mid-line beat pending means replay is running, so input is held off
	`BLD_ASSERT_NOW(a_midline_no_input, clk, arst_n, out_valid && !end_of_line, !in_ready)

	// a data byte never creates an output beat
	`BLD_ASSERT_NEXT(a_data_no_out, clk, arst_n,
		in_valid && in_ready && (in_byte != bld_pkg::NEWLINE_BYTE) && !out_valid,
		!out_valid)

endmodule

bind bounded_line_deframer_unit bld_checker u_bld_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_byte    (in_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.line_byte  (line_byte),
	.end_of_line(end_of_line)
);
`default_nettype wire
